/* design/sse_pkg.sv */
`default_nettype none

package sse_pkg;

   // Store geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int CMP_W  = 11;
   localparam int STEP_W = 4;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     final_res;
      logic [CMP_W-1:0]         comparisons;
   } rsp_type;

   // Microprogram step addresses
   localparam logic [STEP_W-1:0] ST_LOAD    = 4'd0;
   localparam logic [STEP_W-1:0] ST_INIT_I  = 4'd1;
   localparam logic [STEP_W-1:0] ST_RD_I    = 4'd2;
   localparam logic [STEP_W-1:0] ST_PRIME   = 4'd3;
   localparam logic [STEP_W-1:0] ST_SCAN    = 4'd4;
   localparam logic [STEP_W-1:0] ST_SWAP_A  = 4'd5;
   localparam logic [STEP_W-1:0] ST_SWAP_B  = 4'd6;
   localparam logic [STEP_W-1:0] ST_EM_INIT = 4'd7;
   localparam logic [STEP_W-1:0] ST_EM_RD   = 4'd8;
   localparam logic [STEP_W-1:0] ST_EM_OUT  = 4'd9;

   // Memory read address select
   localparam logic [1:0] RD_NONE = 2'd0;
   localparam logic [1:0] RD_I    = 2'd1;
   localparam logic [1:0] RD_J    = 2'd2;

   // Memory write select
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_IN   = 2'd1;
   localparam logic [1:0] WR_BEST = 2'd2;
   localparam logic [1:0] WR_I    = 2'd3;

   // Outer index operation
   localparam logic [1:0] I_HOLD = 2'd0;
   localparam logic [1:0] I_CLR  = 2'd1;
   localparam logic [1:0] I_INC  = 2'd2;

   // Inner index operation
   localparam logic [1:0] J_HOLD   = 2'd0;
   localparam logic [1:0] J_FROM_I = 2'd1;
   localparam logic [1:0] J_INC    = 2'd2;

   // Branch conditions
   localparam logic [1:0] C_ALWAYS  = 2'd0;
   localparam logic [1:0] C_LAST    = 2'd1;
   localparam logic [1:0] C_J_LT_N  = 2'd2;
   localparam logic [1:0] C_I1_LT_N = 2'd3;

   typedef struct packed {
      logic              wait_in;
      logic              wait_out;
      logic [1:0]        rd_sel;
      logic [1:0]        wr_sel;
      logic [1:0]        i_op;
      logic [1:0]        j_op;
      logic              best_init;
      logic              prime;
      logic              scan;
      logic              emit;
      logic [1:0]        cond;
      logic [STEP_W-1:0] tgt_t;
      logic [STEP_W-1:0] tgt_f;
   } ctrl_type;

   typedef struct packed {
      logic go;
      logic last_in;
      logic j_lt_n;
      logic i1_lt_n;
   } status_type;

   // Read-only control store: one control word per step.
   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type cw;
      begin
         cw       = '0;
         cw.cond  = C_ALWAYS;
         cw.tgt_t = ST_LOAD;
         cw.tgt_f = ST_LOAD;
         unique case (step)
            ST_LOAD: begin
               cw.wait_in = 1'b1;
               cw.wr_sel  = WR_IN;
               cw.cond    = C_LAST;
               cw.tgt_t   = ST_INIT_I;
               cw.tgt_f   = ST_LOAD;
            end
            ST_INIT_I: begin
               cw.i_op  = I_CLR;
               cw.tgt_t = ST_RD_I;
            end
            ST_RD_I: begin
               cw.rd_sel    = RD_I;
               cw.best_init = 1'b1;
               cw.j_op      = J_FROM_I;
               cw.tgt_t     = ST_PRIME;
            end
            ST_PRIME: begin
               cw.prime  = 1'b1;
               cw.rd_sel = RD_J;
               cw.j_op   = J_INC;
               cw.cond   = C_J_LT_N;
               cw.tgt_t  = ST_SCAN;
               cw.tgt_f  = ST_SWAP_A;
            end
            ST_SCAN: begin
               cw.scan   = 1'b1;
               cw.rd_sel = RD_J;
               cw.j_op   = J_INC;
               cw.cond   = C_J_LT_N;
               cw.tgt_t  = ST_SCAN;
               cw.tgt_f  = ST_SWAP_A;
            end
            ST_SWAP_A: begin
               cw.wr_sel = WR_BEST;
               cw.tgt_t  = ST_SWAP_B;
            end
            ST_SWAP_B: begin
               cw.wr_sel = WR_I;
               cw.i_op   = I_INC;
               cw.cond   = C_I1_LT_N;
               cw.tgt_t  = ST_RD_I;
               cw.tgt_f  = ST_EM_INIT;
            end
            ST_EM_INIT: begin
               cw.i_op  = I_CLR;
               cw.tgt_t = ST_EM_RD;
            end
            ST_EM_RD: begin
               cw.rd_sel = RD_I;
               cw.tgt_t  = ST_EM_OUT;
            end
            ST_EM_OUT: begin
               cw.wait_out = 1'b1;
               cw.emit     = 1'b1;
               cw.i_op     = I_INC;
               cw.cond     = C_I1_LT_N;
               cw.tgt_t    = ST_EM_RD;
               cw.tgt_f    = ST_LOAD;
            end
            default: begin
               cw.tgt_t = ST_LOAD;
            end
         endcase
         return cw;
      end
   endfunction

endpackage

`default_nettype wire

/* design/sse_sequencer.sv */
`default_nettype none

module sse_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sse_pkg::status_type   status,
   output sse_pkg::ctrl_type          ctrl
);

   logic [sse_pkg::STEP_W-1:0] upc_ff;
   logic [sse_pkg::STEP_W-1:0] upc_in;
   logic                       cond_true;

   assign ctrl = sse_pkg::ucode(upc_ff);

   always_comb begin
      unique case (ctrl.cond)
         sse_pkg::C_ALWAYS:  cond_true = 1'b1;
         sse_pkg::C_LAST:    cond_true = status.last_in;
         sse_pkg::C_J_LT_N:  cond_true = status.j_lt_n;
         sse_pkg::C_I1_LT_N: cond_true = status.i1_lt_n;
         default:            cond_true = 1'b1;
      endcase
   end

   // A step that waits on a handshake holds the step counter.
   always_comb begin
      if (status.go) begin
         upc_in = cond_true ? ctrl.tgt_t : ctrl.tgt_f;
      end else begin
         upc_in = upc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= sse_pkg::ST_LOAD;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

/* design/sse_datapath.sv */
`default_nettype none

module sse_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sse_pkg::ctrl_type   ctrl,
   output sse_pkg::status_type      status,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire sse_pkg::req_type    req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output sse_pkg::rsp_type         rsp_data
);

   localparam int AW = sse_pkg::ADDR_W;
   localparam int CW = sse_pkg::CNT_W;
   localparam int DW = sse_pkg::DATA_W;
   localparam int KW = sse_pkg::CMP_W;

   logic [DW-1:0] elem_mem_ff [sse_pkg::DEPTH];
   logic [DW-1:0] rdata_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [KW-1:0] cmp_ff, cmp_in;
   logic [AW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [AW-1:0] jp_ff, jp_in;
   logic [AW-1:0] best_ff, best_in;
   logic [DW-1:0] best_val_ff, best_val_in;
   logic [DW-1:0] ival_ff, ival_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sse_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          out_free;
   logic          go;
   logic          not_full;
   logic          i1_lt_n;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;

   assign req_stall = !ctrl.wait_in;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go       = !(ctrl.wait_in && !req_valid) && !(ctrl.wait_out && !out_free);
   assign not_full = count_ff < CW'(sse_pkg::DEPTH);
   assign i1_lt_n  = (CW'(i_ff) + CW'(1)) < count_ff;

   assign status.go      = go;
   assign status.last_in = req_data.last;
   assign status.j_lt_n  = j_ff < count_ff;
   assign status.i1_lt_n = i1_lt_n;

   // Memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = req_data.value;
      case (ctrl.wr_sel)
         sse_pkg::WR_IN: begin
            mem_we    = go && not_full;
            mem_waddr = count_ff[AW-1:0];
            mem_wdata = req_data.value;
         end
         sse_pkg::WR_BEST: begin
            mem_we    = go;
            mem_waddr = best_ff;
            mem_wdata = ival_ff;
         end
         sse_pkg::WR_I: begin
            mem_we    = go;
            mem_waddr = i_ff;
            mem_wdata = best_val_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase

      mem_re    = 1'b0;
      mem_raddr = i_ff;
      case (ctrl.rd_sel)
         sse_pkg::RD_I: begin
            mem_re    = go;
            mem_raddr = i_ff;
         end
         sse_pkg::RD_J: begin
            mem_re    = go;
            mem_raddr = j_ff[AW-1:0];
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         elem_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= elem_mem_ff[mem_raddr];
      end
   end

   // Next values of the working registers
   always_comb begin
      count_in     = count_ff;
      cmp_in       = cmp_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jp_in        = jp_ff;
      best_in      = best_ff;
      best_val_in  = best_val_ff;
      ival_in      = ival_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (go) begin
         if (ctrl.wr_sel == sse_pkg::WR_IN && not_full) begin
            count_in = count_ff + CW'(1);
         end

         case (ctrl.i_op)
            sse_pkg::I_CLR: i_in = '0;
            sse_pkg::I_INC: i_in = i_ff + AW'(1);
            default:        i_in = i_ff;
         endcase

         case (ctrl.j_op)
            sse_pkg::J_FROM_I: j_in = CW'(i_ff) + CW'(1);
            sse_pkg::J_INC:    j_in = j_ff + CW'(1);
            default:           j_in = j_ff;
         endcase

         if (ctrl.best_init) begin
            best_in = i_ff;
         end

         if (ctrl.prime) begin
            best_val_in = rdata_ff;
            ival_in     = rdata_ff;
            jp_in       = j_ff[AW-1:0];
         end

         if (ctrl.scan) begin
            if ($signed(rdata_ff) < $signed(best_val_ff)) begin
               best_in     = jp_ff;
               best_val_in = rdata_ff;
            end
            cmp_in = cmp_ff + KW'(1);
            jp_in  = j_ff[AW-1:0];
         end

         if (ctrl.emit) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.sorted_value = rdata_ff;
            rsp_data_in.final_res    = !i1_lt_n;
            rsp_data_in.comparisons  = cmp_ff;
            if (!i1_lt_n) begin
               count_in = '0;
               cmp_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_ff       <= cmp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      jp_ff       <= jp_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      ival_ff     <= ival_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* design/selection_sort_engine_core.sv */
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_data  (value, last)
// rsp_      out        rsp_valid/rsp_stall  rsp_data  (sorted_value, final_res, comparisons)
//
// Loading accepts one request transaction per cycle. After one marked last, the n elements are sorted,
// paced by the single read port of the element memory, then emitted after a set-up step, each
// response transaction taking a read step and an output step. Synchronous active-high reset
// clears the step counter, the element and comparison counts and the response valid flag, but
// not the element memory. A response stall holds the emitting step; req_stall is low only while
// the sequencer sits in its load step.

module selection_sort_engine_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire sse_pkg::req_type   req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sse_pkg::rsp_type        rsp_data
);

   // The control word from the microcode store drives the datapath, and the
   // datapath returns its branch flags and the handshake go signal.
   sse_pkg::ctrl_type   ctrl;
   sse_pkg::status_type status;

   sse_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // The datapath holds the element memory, the loop indices, the running
   // minimum and the output register that parts the response side.
   sse_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* verif/tb.sv */
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Self-checking bench for the selection sort engine.
   //
   // Request transactions carry one signed element each; a transaction marked last
   // closes the set, after which the engine sorts what it holds and returns one
   // response transaction per stored element in ascending order. The bench keeps its
   // own copy of the element store and count, sorts the set itself by selection sort
   // when a closing transaction is accepted, and queues the responses it then awaits.
   // Every accepted response is checked field by field against the oldest of those.
   //
   // The stimulus opens with hand-picked sets (single elements at both extremes,
   // pairs in both orders, equal elements, mixed extremes, sets already sorted and
   // reversed), followed by random sets in four flow-control phases. One set
   // overruns the 64-entry store so that elements are dropped, the closing one
   // included. Early on the response side holds off for a long stretch while
   // requests keep coming, so that the engine fills up and back-pressures its input.

   typedef enum int unsigned {FILL_WIDE, FILL_NARROW, FILL_EDGE} fill_mode_type;

   localparam logic signed [sse_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [sse_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

   // A 64-element sort passes with no transaction on either side, and so does the
   // long hold-off, so the quiet limit is set far beyond both.
   localparam int unsigned QUIET_LIMIT  = 50000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned PHASE_ITEMS  = 30;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sse_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sse_pkg::rsp_type rsp_data;

   always #1 clock = ~clock;

   selection_sort_engine_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The bench's own view of the engine: the elements held for the current set
   // and how many of them there are.
   logic signed [sse_pkg::DATA_W-1:0] held_elems [sse_pkg::DEPTH];
   int unsigned                       held_count = 0;

   sse_pkg::rsp_type sorted_due [$];   // responses awaited, oldest first
   sse_pkg::req_type pending_reqs [$]; // request transactions not yet offered

   int unsigned pushed_count  = 0;
   int unsigned taken_count   = 0;
   int unsigned results_seen  = 0;
   int unsigned error_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_left     = 0;
   int unsigned quiet_cycles  = 0;
   bit          hold_done     = 1'b0;
   bit          req_took      = 1'b0;
   bit          rsp_took      = 1'b0;

   // Store an accepted element and, if it closes the set, sort the set and queue
   // the responses that the engine must return for it.
   task automatic absorb_element(input sse_pkg::req_type item);
      logic signed [sse_pkg::DATA_W-1:0] ranked [sse_pkg::DEPTH];
      logic signed [sse_pkg::DATA_W-1:0] swap_tmp;
      int unsigned                       best;
      int unsigned                       cmp_count;
      sse_pkg::rsp_type                  due;
      // Once the store is full, further elements are dropped; a closing one
      // still starts the sort.
      if (held_count < sse_pkg::DEPTH) begin
         held_elems[held_count] = item.value;
         held_count++;
      end
      if (item.last) begin
         ranked    = held_elems;
         cmp_count = 0;
         for (int unsigned i = 0; i < held_count; i++) begin
            best = i;
            for (int unsigned j = i + 1; j < held_count; j++) begin
               if (ranked[j] < ranked[best]) begin
                  best = j;
               end
               cmp_count++;
            end
            swap_tmp     = ranked[i];
            ranked[i]    = ranked[best];
            ranked[best] = swap_tmp;
         end
         for (int unsigned k = 0; k < held_count; k++) begin
            due.sorted_value = ranked[k];
            due.final_res    = (k + 1 == held_count);
            due.comparisons  = sse_pkg::CMP_W'(cmp_count);
            sorted_due.push_back(due);
         end
         held_count = 0;
      end
   endtask

   task automatic check_result(input sse_pkg::rsp_type got);
      sse_pkg::rsp_type want;
      if (sorted_due.size() == 0) begin
         $error("unexpected response: sorted_value %0d final_res %0b comparisons %0d",
                got.sorted_value, got.final_res, got.comparisons);
         error_count++;
      end else begin
         want = sorted_due.pop_front();
         if (got.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
            error_count++;
         end
         if (got.final_res !== want.final_res) begin
            $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
            error_count++;
         end
         if (got.comparisons !== want.comparisons) begin
            $error("comparisons: expected %0d, got %0d", want.comparisons, got.comparisons);
            error_count++;
         end
      end
   endtask

   function automatic logic signed [sse_pkg::DATA_W-1:0] pick_value(input fill_mode_type mode);
      case (mode)
         FILL_WIDE: begin
            return $urandom;
         end
         FILL_NARROW: begin
            // A narrow band around zero gives plenty of equal elements.
            return $signed({29'b0, 3'($urandom_range(7))}) - 4;
         end
         default: begin
            case ($urandom_range(4))
               0:       return VAL_MAX;
               1:       return VAL_MIN;
               2:       return '0;
               3:       return -1;
               default: return 1;
            endcase
         end
      endcase
   endfunction

   task automatic push_item(input logic signed [sse_pkg::DATA_W-1:0] value, input bit last);
      sse_pkg::req_type item;
      item.value = value;
      item.last  = last;
      pending_reqs.push_back(item);
      pushed_count++;
   endtask

   task automatic queue_random_set(input int unsigned n, input fill_mode_type mode);
      for (int unsigned i = 0; i < n; i++) begin
         push_item(pick_value(mode), i == n - 1);
      end
   endtask

   task automatic queue_random_sets(input int unsigned target);
      int unsigned added;
      int unsigned n;
      added = 0;
      while (added < target) begin
         n = $urandom_range(1, 8);
         queue_random_set(n, fill_mode_type'($urandom_range(2)));
         added += n;
      end
   endtask

   // Wait until every request transaction has been taken and every awaited
   // response has arrived.
   task automatic wait_drained();
      while (taken_count < pushed_count || sorted_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Sampling at the rising edge: the values seen here are those that held before
   // the edge, so a transaction counts exactly when the engine takes it.
   always @(posedge clock) begin
      req_took = !reset && req_valid && !req_stall;
      rsp_took = !reset && rsp_valid && !rsp_stall;
      if (req_took) begin
         absorb_element(req_data);
         taken_count++;
      end
      if (rsp_took) begin
         check_result(rsp_data);
         results_seen++;
      end
      // Watchdog: too long without any transaction means the engine has hung.
      quiet_cycles = (req_took || rsp_took) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** selection_sort_engine_core: FAILED **");
         $finish;
      end
   end

   // Request driver. A new transaction is chosen only once the previous one has
   // been taken, so an offered payload stays put while the engine stalls it, and
   // whether to go idle is decided without looking at the stall.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side. Shortly after the first few responses it holds off for a long
   // stretch while requests are still being offered; otherwise it stalls at the
   // rate of the current phase.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && results_seen >= 6) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hand-picked sets, with neither side idling at random.
      push_item(VAL_MAX, 1'b1);
      push_item(VAL_MIN, 1'b1);
      push_item(VAL_MAX, 1'b0);
      push_item(VAL_MIN, 1'b1);
      push_item(VAL_MIN, 1'b0);
      push_item(VAL_MAX, 1'b1);
      push_item(-1, 1'b0);
      push_item(-1, 1'b1);
      push_item(0, 1'b0);
      push_item(-1, 1'b0);
      push_item(1, 1'b0);
      push_item(VAL_MAX, 1'b0);
      push_item(VAL_MIN, 1'b1);
      for (int v = -2; v <= 1; v++) begin
         push_item(v, v == 1);
      end
      for (int v = 4; v >= 0; v--) begin
         push_item(v, v == 0);
      end
      queue_random_set(3, FILL_WIDE);

      // Random sets, then one that overruns the store: the last two elements,
      // the closing one among them, are dropped.
      queue_random_sets(PHASE_ITEMS);
      queue_random_set(sse_pkg::DEPTH + 2, FILL_WIDE);
      wait_drained();

      send_idle_pct = 68;
      rsp_stall_pct = 0;
      queue_random_sets(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 0;
      rsp_stall_pct = 68;
      queue_random_sets(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 29;
      rsp_stall_pct = 29;
      queue_random_sets(PHASE_ITEMS);
      wait_drained();

      // Let the engine settle, in case anything stray is still to come out.
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (sorted_due.size() != 0) begin
         $error("%0d awaited responses never arrived", sorted_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("** selection_sort_engine_core: PASSED **");
      end else begin
         $display("** selection_sort_engine_core: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
design/sse_pkg.sv
design/sse_sequencer.sv
design/sse_datapath.sv
design/selection_sort_engine_core.sv
verif/tb.sv
